// File: src/text_console_char_writer_core_defines.svh
// assertion macros used by the console back end
`ifndef TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_WRITER_CORE_DEFINES_SVH

// same-cycle implication, needs i_clk and i_rst_n in scope
`define TCCW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tccw_pkg.sv
`default_nettype none

package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int OPCODE_W = 1;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int POS_W    = 11;
    localparam int CELL_W   = 16;
    localparam int COLOR_W  = 8;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam int TAB_STEP = 4;

    localparam logic [OPCODE_W-1:0] OP_PUT  = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_READ = 1'b1;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;
    localparam logic [CELL_W-1:0]  CLEAR_CELL  = {RESET_COLOR, CH_SPACE};

    typedef logic [2:0] t_kind;
    localparam t_kind K_CHAR = 3'd0;
    localparam t_kind K_BS   = 3'd1;
    localparam t_kind K_TAB  = 3'd2;
    localparam t_kind K_NL   = 3'd3;
    localparam t_kind K_READ = 3'd4;

    typedef struct packed {
        t_kind              kind;
        logic [CHAR_W-1:0]  char_code;
        logic [IDX_W-1:0]   cell_index;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

`default_nettype wire

// File: src/tccw_if.sv
`default_nettype none

interface tccw_in_if;
    logic                           valid;
    logic                           ready;
    logic [tccw_pkg::OPCODE_W-1:0]  opcode;
    logic [tccw_pkg::CHAR_W-1:0]    char_code;
    logic [tccw_pkg::IDX_W-1:0]     cell_index;

    modport source (output valid, output opcode, output char_code, output cell_index,
                    input ready);
    modport sink (input valid, input opcode, input char_code, input cell_index,
                  output ready);
endinterface

interface tccw_out_if;
    logic                           valid;
    logic                           ready;
    logic [tccw_pkg::POS_W-1:0]     cursor_pos;
    logic [tccw_pkg::CELL_W-1:0]    cell_data;

    modport source (output valid, output cursor_pos, output cell_data, input ready);
    modport sink (input valid, input cursor_pos, input cell_data, output ready);
endinterface

`default_nettype wire

// File: src/text_console_char_writer_core.sv
`default_nettype none

// Character-cell text console. Put items write a character at the cursor (tab and
// newline are handled as cursor moves, backspace steps back and blanks that cell) and
// read items return one 16-bit cell; every item returns one result with the linear
// cursor position. A front end classifies incoming items into a two-entry queue, and
// the back end, which owns the screen memory (one write port, one read port) and the
// cursor, takes one item at a time: it executes the item, then loads the output register
// once that is free. A put that wraps past the last row scrolls the screen by walking
// the memory, copying one cell a cycle and then filling the bottom line. After reset the
// memory is cleared to space on light grey, one cell a cycle, and no item is accepted
// until the clear is done; color writes are taken at any time.
module text_console_char_writer_core #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    tccw_in_if.sink                       i_in,
    tccw_out_if.source                    o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [tccw_pkg::COLOR_W-1:0]  i_cfg_wr_data
);

    tccw_pkg::t_back_stat stat;
    tccw_pkg::t_cmd       push_cmd;
    tccw_pkg::t_cmd       head_cmd;
    logic                 push;
    logic                 full;
    logic                 head_valid;
    logic                 pop;

    tccw_front u_front (
        .i_in   (i_in),
        .i_stat (stat),
        .i_full (full),
        .o_push (push),
        .o_cmd  (push_cmd)
    );

    tccw_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (full),
        .o_valid    (head_valid),
        .o_cmd      (head_cmd),
        .i_pop      (pop)
    );

    tccw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (head_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_stat        (stat),
        .o_out         (o_out)
    );

endmodule

`default_nettype wire

// File: src/tccw_queue.sv
`default_nettype none

module tccw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tccw_pkg::t_cmd i_push_cmd,
    output logic           o_full,
    output logic           o_valid,
    output tccw_pkg::t_cmd o_cmd,
    input  logic           i_pop
);

    localparam int CNT_W = tccw_pkg::QUEUE_AW + 1;

    tccw_pkg::t_cmd              r_slot [tccw_pkg::QUEUE_DEPTH];
    logic [tccw_pkg::QUEUE_AW-1:0] r_wp;
    logic [tccw_pkg::QUEUE_AW-1:0] r_rp;
    logic [CNT_W-1:0]            r_cnt;

    assign o_full  = (r_cnt == CNT_W'(tccw_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + tccw_pkg::QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + tccw_pkg::QUEUE_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: src/tccw_front.sv
`default_nettype none

module tccw_front (
    tccw_in_if.sink              i_in,
    input  tccw_pkg::t_back_stat i_stat,
    input  logic                 i_full,
    output logic                 o_push,
    output tccw_pkg::t_cmd       o_cmd
);

    // no items taken while the screen store is being cleared
    assign i_in.ready = !i_full && !i_stat.clearing;
    assign o_push     = i_in.valid && i_in.ready;

    always_comb begin
        o_cmd.char_code  = i_in.char_code;
        o_cmd.cell_index = i_in.cell_index;
        priority if (i_in.opcode == tccw_pkg::OP_READ) begin
            o_cmd.kind = tccw_pkg::K_READ;
        end else if (i_in.char_code == tccw_pkg::CH_BACKSPACE) begin
            o_cmd.kind = tccw_pkg::K_BS;
        end else if (i_in.char_code == tccw_pkg::CH_TAB) begin
            o_cmd.kind = tccw_pkg::K_TAB;
        end else if (i_in.char_code == tccw_pkg::CH_NEWLINE) begin
            o_cmd.kind = tccw_pkg::K_NL;
        end else begin
            o_cmd.kind = tccw_pkg::K_CHAR;
        end
    end

endmodule

`default_nettype wire

// File: src/tccw_back.sv
`default_nettype none

`include "text_console_char_writer_core_defines.svh"

module tccw_back #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  tccw_pkg::t_cmd                i_cmd,
    output logic                          o_pop,
    input  logic                          i_cfg_wr_en,
    input  logic [tccw_pkg::COLOR_W-1:0]  i_cfg_wr_data,
    output tccw_pkg::t_back_stat          o_stat,
    tccw_out_if.source                    o_out
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS + tccw_pkg::TAB_STEP + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int XW    = ((AW > tccw_pkg::IDX_W) ? AW : tccw_pkg::IDX_W) + 1;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RESP  = 3'd2;
    localparam logic [2:0] S_COPY  = 3'd3;
    localparam logic [2:0] S_FILL  = 3'd4;

    logic [tccw_pkg::CELL_W-1:0]  r_mem [CELLS];
    logic [2:0]                   r_state;
    logic [AW-1:0]                r_addr;
    logic [RW-1:0]                r_row;
    logic [CW-1:0]                r_col;
    logic [AW-1:0]                r_row_base;
    logic [tccw_pkg::COLOR_W-1:0] r_color;
    logic                         r_is_read;
    logic                         r_rd_ok;
    logic [tccw_pkg::CELL_W-1:0]  r_rd_data;
    logic                         r_cp_valid;
    logic [AW-1:0]                r_cp_dst;
    logic                         r_out_valid;
    logic [tccw_pkg::POS_W-1:0]   r_out_pos;
    logic [tccw_pkg::CELL_W-1:0]  r_out_data;

    logic                         exec;
    logic [CW-1:0]                bs_col;
    logic [CW-1:0]                step_col;
    logic [CW-1:0]                wr_col;
    logic                         wrap;
    logic                         last_row;
    logic [XW-1:0]                idx_x;
    logic [XW-1:0]                pos_x;
    logic                         out_free;
    logic                         we;
    logic [AW-1:0]                wa;
    logic [tccw_pkg::CELL_W-1:0]  wd;
    logic                         rd_en;
    logic [AW-1:0]                ra;

    assign exec     = (r_state == S_IDLE) && i_cmd_valid;
    assign o_pop    = exec;
    assign bs_col   = (r_col != '0) ? (r_col - CW'(1)) : r_col;
    // tab moves by the tab step and then by the ordinary one
    assign step_col = r_col + ((i_cmd.kind == tccw_pkg::K_TAB)
                               ? CW'(tccw_pkg::TAB_STEP + 1) : CW'(1));
    assign wrap     = (i_cmd.kind == tccw_pkg::K_NL) || (step_col >= CW'(COLUMNS));
    assign wr_col   = (i_cmd.kind == tccw_pkg::K_BS) ? bs_col : r_col;
    assign last_row = (r_row == RW'(ROWS - 1));
    assign idx_x    = XW'(i_cmd.cell_index);
    assign pos_x    = XW'(r_row_base) + XW'(r_col);
    assign out_free = !r_out_valid || o_out.ready;

    assign o_stat.clearing  = (r_state == S_CLEAR);
    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_pos = r_out_pos;
    assign o_out.cell_data  = r_out_data;

    // single write port: clear sweep, pending scroll copy, bottom fill, then puts
    always_comb begin
        we = 1'b0;
        wa = r_addr;
        wd = tccw_pkg::CLEAR_CELL;
        priority if (r_state == S_CLEAR) begin
            we = 1'b1;
        end else if (r_cp_valid) begin
            we = 1'b1;
            wa = r_cp_dst;
            wd = r_rd_data;
        end else if (r_state == S_FILL) begin
            we = 1'b1;
            wd = {r_color, tccw_pkg::CH_SPACE};
        end else if (exec && (i_cmd.kind == tccw_pkg::K_CHAR
                              || i_cmd.kind == tccw_pkg::K_BS)) begin
            we = 1'b1;
            wa = r_row_base + AW'(wr_col);
            wd = {r_color, (i_cmd.kind == tccw_pkg::K_BS) ? tccw_pkg::CH_SPACE
                                                          : i_cmd.char_code};
        end else begin
            we = 1'b0;
        end
    end

    assign rd_en = (r_state == S_COPY) || (exec && (i_cmd.kind == tccw_pkg::K_READ));
    assign ra    = (r_state == S_COPY) ? r_addr : idx_x[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wa] <= wd;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_is_read <= (i_cmd.kind == tccw_pkg::K_READ);
            r_rd_ok   <= (idx_x < XW'(CELLS));
        end
        if (r_state == S_COPY) begin
            r_cp_dst <= r_addr - AW'(COLUMNS);
        end
        if ((r_state == S_RESP) && out_free) begin
            r_out_pos  <= pos_x[tccw_pkg::POS_W-1:0];
            r_out_data <= (r_is_read && r_rd_ok) ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_addr      <= '0;
            r_row       <= '0;
            r_col       <= '0;
            r_row_base  <= '0;
            r_color     <= tccw_pkg::RESET_COLOR;
            r_cp_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
            // read one cell a cycle while copying, written a line up in the next cycle
            r_cp_valid <= (r_state == S_COPY);
            if ((r_state == S_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_addr <= r_addr + AW'(1);
                    if (r_addr == AW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (exec) begin
                        if ((i_cmd.kind != tccw_pkg::K_BS) && (i_cmd.kind != tccw_pkg::K_READ)
                            && wrap && last_row) begin
                            r_state <= S_COPY;
                        end else begin
                            r_state <= S_RESP;
                        end
                        if (i_cmd.kind == tccw_pkg::K_BS) begin
                            r_col <= bs_col;
                        end else if (i_cmd.kind != tccw_pkg::K_READ) begin
                            if (wrap) begin
                                r_col <= '0;
                                if (last_row) begin
                                    r_addr <= AW'(COLUMNS);
                                end else begin
                                    r_row      <= r_row + RW'(1);
                                    r_row_base <= r_row_base + AW'(COLUMNS);
                                end
                            end else begin
                                r_col <= step_col;
                            end
                        end
                    end
                end
                S_COPY: begin
                    if (r_addr == AW'(CELLS - 1)) begin
                        r_state <= S_FILL;
                        r_addr  <= AW'(LAST_ROW_BASE);
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_FILL: begin
                    if (!r_cp_valid) begin
                        if (r_addr == AW'(CELLS - 1)) begin
                            r_state <= S_RESP;
                        end else begin
                            r_addr <= r_addr + AW'(1);
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TCCW_ASSERT_NOW(a_col_in_line, r_state != S_CLEAR, r_col < CW'(COLUMNS), "cursor column past line end")
    `TCCW_ASSERT_NOW(a_row_base, 1'b1, r_row_base == AW'(r_row * COLUMNS), "row base out of step with row")
    `TCCW_ASSERT_NEXT(a_one_at_a_time, o_pop, r_state != S_IDLE, "back end took a second item early")
    `TCCW_ASSERT_NOW(a_copy_in_scroll, r_cp_valid, r_state == S_COPY || r_state == S_FILL, "copy write outside scroll")

endmodule

`default_nettype wire
